// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MRC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MRC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/mrc_pkg.sv
// ----------------------------------------------------------------------------
// Modbus RTU response checker package
// Shared types, codes and constants of the response checker.
// ----------------------------------------------------------------------------
`default_nettype none

package mrc_pkg;

  localparam int          MAX_REGS_DEF   = 64;
  localparam logic [15:0] TIMEOUT_RST    = 16'd1000;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [7:0]  FUNC_READ_HOLD = 8'h03;
  localparam logic [7:0]  EXC_MASK       = 8'h80;
  localparam logic [7:0]  READ_OVERHEAD  = 8'd5;
  localparam logic [7:0]  WRITE_LEN      = 8'd8;

  typedef enum logic [1:0] {
    CMD_START_READ,
    CMD_START_WRITE,
    CMD_RX_BYTE,
    CMD_TICK
  } cmd_t;

  typedef enum logic [2:0] {
    KIND_READ_VALUE,
    KIND_WRITE_OK,
    KIND_READ_FAIL,
    KIND_WRITE_FAIL,
    KIND_READ_TIMEOUT,
    KIND_WRITE_TIMEOUT,
    KIND_NOT_CONNECTED
  } kind_t;

  typedef enum logic {
    REG_LINK_UP,
    REG_TIMEOUT_TICKS
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_LOAD
  } state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] base_addr;
    logic [6:0]  num_regs;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] echo_addr;
    logic [5:0]  reg_index;
    logic [15:0] reg_value;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/mrc_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/mrc_crc.sv
// ----------------------------------------------------------------------------
// CRC-16/MODBUS byte update
// Folds one byte into the running reflected CRC, one bit per step.
// ----------------------------------------------------------------------------
`default_nettype none

module mrc_crc (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);

  localparam logic [15:0] POLY = 16'hA001;

  logic [15:0] acc;

  always_comb begin
    acc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (acc[0]) begin
        acc = (acc >> 1) ^ POLY;
      end else begin
        acc = acc >> 1;
      end
    end
    crc_out = acc;
  end

endmodule

`default_nettype wire

// File: rtl/modbus_rtu_response_checker.sv
// Handshake: a result that an item causes sits in the output register right after the
// accepting edge. The next item is taken once the checker is idle and the output
// register is free or its result transfers in that same cycle.
// A valid read response replays its m values one at a time through the single read
// port of the value store (read, then load); the input waits until the last loads.
// Reset: synchronous, active high; resets control state and configuration, not the store.
// ----------------------------------------------------------------------------
// Modbus RTU response checker
// Master side of a Modbus RTU exchange: tracks one read-holding-registers or
// write-single-register transaction, checks the response frame by CRC-16 and
// function code, and replays the register values of a good read.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module modbus_rtu_response_checker
  import mrc_pkg::*;
#(
  parameter int MAX_REGS = MAX_REGS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  // Command / byte / tick channel.
  input  logic           item_valid,
  output logic           item_ready,
  input  item_t          item,
  // Result channel.
  output logic           result_valid,
  input  logic           result_ready,
  output result_t        result,
  // Configuration write port.
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [15:0]    cfg_wdata
);

  // Store index width; 7-bit counts need MAX_REGS at most 125, kept by the user, unchecked.
  localparam int         IDX_W = (MAX_REGS > 1) ? $clog2(MAX_REGS) : 1;
  localparam logic [6:0] MAX_N = 7'(MAX_REGS);

  // Configuration registers.
  logic        link_up;
  logic [15:0] timeout_ticks;

  // Transaction state and its next values.
  state_t      state, state_next;
  logic        busy, busy_next;
  logic        is_write, is_write_next;
  logic [15:0] current_addr, current_addr_next;
  logic [6:0]  n_regs, n_regs_next;
  logic [7:0]  expected_length, expected_length_next;
  logic [7:0]  bytes_received, bytes_received_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  function_byte, function_byte_next;
  logic [7:0]  byte_count_field, byte_count_field_next;
  logic [7:0]  high_byte_hold, high_byte_hold_next;
  logic [15:0] timeout_left, timeout_left_next;
  logic [6:0]  rd_idx, rd_idx_next;
  logic [6:0]  rep_last, rep_last_next;

  // Output register load.
  logic        load_out;
  result_t     out_new;

  // Value store access.
  logic             ram_we;
  logic             ram_re;
  logic [IDX_W-1:0] ram_waddr;
  logic [IDX_W-1:0] ram_raddr;
  logic [15:0]      ram_wdata;
  logic [15:0]      ram_rdata;

  // Helpers.
  logic        item_fire;
  logic        out_free;
  logic [6:0]  cnt_sat;
  logic [7:0]  body_off;
  logic [6:0]  wr_i;
  logic        in_body;
  logic [7:0]  rx_count;
  logic [6:0]  bc_half;
  logic [6:0]  rep_count;
  logic [15:0] timeout_dec;
  logic [15:0] crc_new;

  // The output register frees up in the same cycle its result transfers, so a new
  // item can be taken while the previous result is on its way out.
  assign out_free   = !result_valid || result_ready;
  assign item_ready = (state == ST_IDLE) && out_free;
  assign item_fire  = item_valid && item_ready;

  // A register count of zero means one; anything above the store depth saturates.
  assign cnt_sat = (item.num_regs == 7'd0) ? 7'd1 :
                   (item.num_regs > MAX_N) ? MAX_N : item.num_regs;

  // Data bytes of a read response start at position 3 and stop before the CRC.
  assign body_off = bytes_received - 8'd3;
  assign wr_i     = body_off[7:1];
  assign in_body  = (bytes_received >= 8'd3) && !is_write &&
                    (({1'b0, bytes_received} + 9'd2) < {1'b0, expected_length});
  assign rx_count = bytes_received + 8'd1;

  // Values to replay: the byte count field in whole registers, clamped to the request.
  assign bc_half   = byte_count_field[7:1];
  assign rep_count = (bc_half > n_regs) ? n_regs : bc_half;

  assign timeout_dec = timeout_left - 16'd1;

  assign ram_waddr = wr_i[IDX_W-1:0];
  assign ram_wdata = {high_byte_hold, item.rx_byte};
  assign ram_raddr = rd_idx[IDX_W-1:0];

  mrc_crc u_crc (
    .crc_in  (running_crc),
    .data    (item.rx_byte),
    .crc_out (crc_new)
  );

  mrc_ram #(
    .WIDTH (16),
    .DEPTH (MAX_REGS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next-state and datapath control. Store writes happen only while bytes of a frame
  // arrive, and reads only during replay, which begins after the last byte; the
  // last write therefore lands before the first read.
  always_comb begin
    state_next            = state;
    busy_next             = busy;
    is_write_next         = is_write;
    current_addr_next     = current_addr;
    n_regs_next           = n_regs;
    expected_length_next  = expected_length;
    bytes_received_next   = bytes_received;
    running_crc_next      = running_crc;
    function_byte_next    = function_byte;
    byte_count_field_next = byte_count_field;
    high_byte_hold_next   = high_byte_hold;
    timeout_left_next     = timeout_left;
    rd_idx_next           = rd_idx;
    rep_last_next         = rep_last;
    load_out              = 1'b0;
    out_new               = '0;
    ram_we                = 1'b0;
    ram_re                = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (item_fire) begin
          unique case (cmd_t'(item.cmd))
            CMD_START_READ, CMD_START_WRITE: begin
              if (!link_up) begin
                // Rejected start: reported even while a transaction is open.
                load_out          = 1'b1;
                out_new.kind      = KIND_NOT_CONNECTED;
                out_new.echo_addr = item.base_addr;
                out_new.last      = 1'b1;
              end else if (!busy) begin
                busy_next             = 1'b1;
                is_write_next         = (item.cmd == CMD_START_WRITE);
                current_addr_next     = item.base_addr;
                n_regs_next           = cnt_sat;
                expected_length_next  = (item.cmd == CMD_START_WRITE) ? WRITE_LEN :
                                        READ_OVERHEAD + {cnt_sat, 1'b0};
                bytes_received_next   = 8'd0;
                running_crc_next      = CRC_INIT;
                function_byte_next    = 8'd0;
                byte_count_field_next = 8'd0;
                high_byte_hold_next   = 8'd0;
                timeout_left_next     = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
              end
            end
            CMD_TICK: begin
              if (busy) begin
                timeout_left_next = timeout_dec;
                if (timeout_dec == 16'd0) begin
                  busy_next         = 1'b0;
                  load_out          = 1'b1;
                  out_new.kind      = is_write ? KIND_WRITE_TIMEOUT : KIND_READ_TIMEOUT;
                  out_new.echo_addr = current_addr;
                  out_new.last      = 1'b1;
                end
              end
            end
            CMD_RX_BYTE: begin
              if (busy) begin
                running_crc_next    = crc_new;
                bytes_received_next = rx_count;
                if (bytes_received == 8'd1) begin
                  function_byte_next = item.rx_byte;
                end else if (bytes_received == 8'd2) begin
                  byte_count_field_next = item.rx_byte;
                end else if (in_body) begin
                  if (!body_off[0]) begin
                    high_byte_hold_next = item.rx_byte;
                  end else if (wr_i < MAX_N) begin
                    ram_we = 1'b1;
                  end
                end
                // Frame complete: the function byte was captured on an earlier byte.
                if (rx_count >= expected_length) begin
                  busy_next = 1'b0;
                  if (is_write) begin
                    load_out          = 1'b1;
                    out_new.kind      = ((crc_new == 16'd0) &&
                                         ((function_byte & EXC_MASK) == 8'd0)) ?
                                        KIND_WRITE_OK : KIND_WRITE_FAIL;
                    out_new.echo_addr = current_addr;
                    out_new.last      = 1'b1;
                  end else if ((crc_new != 16'd0) || (function_byte != FUNC_READ_HOLD)) begin
                    load_out          = 1'b1;
                    out_new.kind      = KIND_READ_FAIL;
                    out_new.echo_addr = current_addr;
                    out_new.last      = 1'b1;
                  end else if (rep_count != 7'd0) begin
                    state_next    = ST_READ;
                    rd_idx_next   = 7'd0;
                    rep_last_next = rep_count - 7'd1;
                  end
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        ram_re     = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        // Read data stays put until the next read, so a stalled output just waits.
        if (out_free) begin
          load_out          = 1'b1;
          out_new.kind      = KIND_READ_VALUE;
          out_new.echo_addr = current_addr;
          out_new.reg_index = rd_idx[5:0];
          out_new.reg_value = ram_rdata;
          out_new.last      = (rd_idx == rep_last);
          if (rd_idx == rep_last) begin
            state_next = ST_IDLE;
          end else begin
            rd_idx_next = rd_idx + 7'd1;
            state_next  = ST_READ;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control and transaction state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      busy             <= 1'b0;
      is_write         <= 1'b0;
      current_addr     <= 16'd0;
      n_regs           <= 7'd0;
      expected_length  <= 8'd0;
      bytes_received   <= 8'd0;
      running_crc      <= CRC_INIT;
      function_byte    <= 8'd0;
      byte_count_field <= 8'd0;
      high_byte_hold   <= 8'd0;
      timeout_left     <= 16'd0;
      rd_idx           <= 7'd0;
      rep_last         <= 7'd0;
      result_valid     <= 1'b0;
      link_up          <= 1'b0;
      timeout_ticks    <= TIMEOUT_RST;
    end else begin
      state            <= state_next;
      busy             <= busy_next;
      is_write         <= is_write_next;
      current_addr     <= current_addr_next;
      n_regs           <= n_regs_next;
      expected_length  <= expected_length_next;
      bytes_received   <= bytes_received_next;
      running_crc      <= running_crc_next;
      function_byte    <= function_byte_next;
      byte_count_field <= byte_count_field_next;
      high_byte_hold   <= high_byte_hold_next;
      timeout_left     <= timeout_left_next;
      rd_idx           <= rd_idx_next;
      rep_last         <= rep_last_next;
      if (load_out) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_LINK_UP:       link_up       <= cfg_wdata[0];
          REG_TIMEOUT_TICKS: timeout_ticks <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (load_out) begin
      result <= out_new;
    end
  end

  // Replay only runs after the transaction has closed.
  `MRC_ASSERT_IMP(a_replay_not_busy, state != ST_IDLE, !busy, "replay while a transaction is open")
  // The value store is never written during replay.
  `MRC_ASSERT_IMP(a_no_write_in_replay, ram_we, state == ST_IDLE, "store write during replay")
  // The replay index stays within the values counted in the frame.
  `MRC_ASSERT_IMP(a_replay_bound, state != ST_IDLE, rd_idx <= rep_last, "replay index overrun")
  // The tick that exhausts the timeout yields a timeout result.
  `MRC_ASSERT_NXT(a_timeout_result,
                  item_fire && item.cmd == CMD_TICK && busy && timeout_left == 16'd1,
                  result_valid && !busy && (result.kind == KIND_READ_TIMEOUT ||
                                            result.kind == KIND_WRITE_TIMEOUT),
                  "missing timeout result")

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Modbus RTU response checker testbench
// Sends start, byte and timer tick transfers into the checker and keeps a
// behavioral model of the master transaction that predicts every result.
// Each result transfer is compared field by field with the oldest
// prediction. The test runs directed frames first, then random frames under
// several idle and stall mixes, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb
  import mrc_pkg::*;
();

  typedef logic [7:0] frame_t[$];

  localparam int          SETTLE_CYCLES     = 10;
  localparam int          CYCLE_LIMIT       = 3_000_000;
  localparam int          HOLD_OFF_CYCLES   = 600;
  localparam int          TICKS_MAX         = 65535;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [7:0]  FUNC_WRITE_SINGLE = 8'h06;

  // --------------------------------------------------------------------------
  // Clock, reset and the ports of the block. Every input has a known value
  // from time zero; after that, inputs only change by nonblocking assignments
  // at the rising edge.
  // --------------------------------------------------------------------------
  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_ready;
  item_t       item         = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  result_t     result;
  logic        cfg_we       = 1'b0;
  logic        cfg_index    = 1'b0;
  logic [15:0] cfg_wdata    = '0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  modbus_rtu_response_checker DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Behavioral model of the master. It holds its own copy of the
  // configuration and of the transaction in flight, and is advanced once per
  // accepted input transfer, in acceptance order.
  // --------------------------------------------------------------------------
  logic        link_open  = 1'b0;
  logic [15:0] tmo_limit  = TIMEOUT_RST;
  logic        txn_open   = 1'b0;
  logic        txn_write  = 1'b0;
  logic [15:0] txn_addr   = '0;
  logic [7:0]  frame_len  = '0;
  logic [7:0]  rx_count   = '0;
  logic [15:0] frame_crc  = CRC_INIT;
  logic [7:0]  func_code  = '0;
  logic [7:0]  byte_cnt   = '0;
  logic [7:0]  hi_hold    = '0;
  logic [15:0] reg_vals [MAX_REGS_DEF];
  logic [15:0] ticks_left = '0;

  // Results the model has produced that have not yet come out of the block.
  result_t txn_outcomes[$];
  result_t want;

  int mismatches      = 0;
  int effective_items = 0;
  int tx_idle_pct     = 0;
  int rx_stall_pct    = 0;
  int hold_left       = 0;
  int cycle_count     = 0;

  // One byte of CRC-16/MODBUS, LSB first with the reflected polynomial.
  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++)
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    return c;
  endfunction

  function automatic void queue_outcome(kind_t k, logic [15:0] a, logic [5:0] idx,
                                        logic [15:0] v, logic l);
    result_t r;
    r.kind      = k;
    r.echo_addr = a;
    r.reg_index = idx;
    r.reg_value = v;
    r.last      = l;
    txn_outcomes.push_back(r);
  endfunction

  // Advances the model by one accepted transfer and queues what it causes.
  // Returns zero when the block simply ignores the transfer.
  function automatic bit predict_txn(item_t it);
    int unsigned n, m, pos, off;
    case (cmd_t'(it.cmd))
      CMD_START_READ, CMD_START_WRITE: begin
        // A start with the link down is reported even while busy.
        if (!link_open) begin
          queue_outcome(KIND_NOT_CONNECTED, it.base_addr, '0, '0, 1'b1);
          return 1'b1;
        end
        if (txn_open) return 1'b0;
        n = it.num_regs;
        if (n < 1) n = 1;
        if (n > MAX_REGS_DEF) n = MAX_REGS_DEF;
        txn_open   = 1'b1;
        txn_write  = (it.cmd == CMD_START_WRITE);
        txn_addr   = it.base_addr;
        frame_len  = txn_write ? WRITE_LEN : 8'(READ_OVERHEAD + 2 * n);
        rx_count   = '0;
        frame_crc  = CRC_INIT;
        func_code  = '0;
        byte_cnt   = '0;
        hi_hold    = '0;
        ticks_left = (tmo_limit == 0) ? 16'd1 : tmo_limit;
        return 1'b1;
      end
      CMD_TICK: begin
        if (!txn_open) return 1'b0;
        ticks_left--;
        if (ticks_left == 0) begin
          txn_open = 1'b0;
          queue_outcome(txn_write ? KIND_WRITE_TIMEOUT : KIND_READ_TIMEOUT,
                        txn_addr, '0, '0, 1'b1);
        end
        return 1'b1;
      end
      default: begin
        // Received response byte.
        if (!txn_open) return 1'b0;
        pos       = rx_count;
        frame_crc = crc16_step(frame_crc, it.rx_byte);
        if (pos == 1) begin
          func_code = it.rx_byte;
        end else if (pos == 2) begin
          byte_cnt = it.rx_byte;
        end else if (pos >= 3 && pos + 2 < frame_len && !txn_write) begin
          off = pos - 3;
          if (off[0] == 1'b0) hi_hold = it.rx_byte;
          else if ((off >> 1) < MAX_REGS_DEF) reg_vals[off >> 1] = {hi_hold, it.rx_byte};
        end
        rx_count = 8'(pos + 1);
        if (rx_count < frame_len) return 1'b1;
        txn_open = 1'b0;
        if (txn_write) begin
          queue_outcome((frame_crc == 0 && (func_code & EXC_MASK) == 0) ?
                        KIND_WRITE_OK : KIND_WRITE_FAIL, txn_addr, '0, '0, 1'b1);
        end else if (frame_crc != 0 || func_code != FUNC_READ_HOLD) begin
          queue_outcome(KIND_READ_FAIL, txn_addr, '0, '0, 1'b1);
        end else begin
          // The byte count field is halved and clamped to the registers asked.
          n = (frame_len - READ_OVERHEAD) / 2;
          m = byte_cnt / 2;
          if (m > n) m = n;
          for (int i = 0; i < m; i++)
            queue_outcome(KIND_READ_VALUE, txn_addr, 6'(i), reg_vals[i], i == m - 1);
        end
        return 1'b1;
      end
    endcase
  endfunction

  function automatic frame_t with_crc(frame_t f);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (f[i]) c = crc16_step(c, f[i]);
    // The CRC goes out low byte first, which leaves a zero residue.
    f.push_back(c[7:0]);
    f.push_back(c[15:8]);
    return f;
  endfunction

  function automatic logic [15:0] rand_addr();
    int r;
    r = $urandom_range(9);
    return (r == 0) ? 16'h0000 : (r == 1) ? 16'hFFFF : 16'($urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Result side. The receiver either holds off for a counted stretch or
  // stalls at random at the current rate. The checker compares every result
  // transfer with the oldest prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= (int'($urandom_range(99)) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (txn_outcomes.size() == 0) begin
        $error("unexpected result: kind %0d, echo_addr %h", result.kind, result.echo_addr);
        mismatches++;
      end else begin
        want = txn_outcomes.pop_front();
        if (result !== want) mismatches++;
        if (result.kind !== want.kind)
          $error("kind: expected %0d, got %0d", want.kind, result.kind);
        if (result.echo_addr !== want.echo_addr)
          $error("echo_addr: expected %h, got %h", want.echo_addr, result.echo_addr);
        if (result.reg_index !== want.reg_index)
          $error("reg_index: expected %0d, got %0d", want.reg_index, result.reg_index);
        if (result.reg_value !== want.reg_value)
          $error("reg_value: expected %h, got %h", want.reg_value, result.reg_value);
        if (result.last !== want.last)
          $error("last: expected %0d, got %0d", want.last, result.last);
      end
    end
  end

  // Guard against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Input side. All tasks are entered in the time step of a rising edge and
  // return in one. The valid line is only lowered when an idle cycle is taken or the
  // test settles, so a valid that stays high is never lowered and raised in one step.
  // --------------------------------------------------------------------------
  task automatic send_item(item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    // The transfer happened at this edge; the model follows in the same order.
    if (predict_txn(it)) effective_items++;
  endtask

  task automatic send_start(cmd_t c, logic [15:0] a, logic [6:0] cnt);
    item_t it;
    it.cmd       = c;
    it.base_addr = a;
    it.num_regs  = cnt;
    it.rx_byte   = 8'($urandom);
    send_item(it);
  endtask

  // Fields a command does not use carry random values so every bit toggles.
  task automatic send_byte(logic [7:0] b);
    item_t it;
    it.cmd       = CMD_RX_BYTE;
    it.base_addr = 16'($urandom);
    it.num_regs  = 7'($urandom);
    it.rx_byte   = b;
    send_item(it);
  endtask

  task automatic send_tick();
    item_t it;
    it.cmd       = CMD_TICK;
    it.base_addr = 16'($urandom);
    it.num_regs  = 7'($urandom);
    it.rx_byte   = 8'($urandom);
    send_item(it);
  endtask

  task automatic send_noise();
    item_t it;
    it = item_t'({$urandom, $urandom});
    send_item(it);
  endtask

  // Sends a frame byte by byte, with timer ticks mixed in at tick_pct.
  task automatic send_frame(frame_t f, int tick_pct);
    foreach (f[i]) begin
      if ($urandom_range(99) < tick_pct) send_tick();
      send_byte(f[i]);
    end
  endtask

  // Finishes whatever transaction is open, by ticks when the timeout is
  // nearer than the end of the frame, else by random bytes.
  task automatic close_open_txn();
    while (txn_open) begin
      if (int'(ticks_left) <= int'(frame_len) - int'(rx_count)) send_tick();
      else send_byte(8'($urandom));
    end
  endtask

  // One transaction: a start and a response frame with random content. Most
  // frames are well formed; some carry a bad function code, a wild byte
  // count, a flipped bit or are cut short.
  task automatic send_txn();
    frame_t     f;
    logic [6:0] cnt;
    int         n, r;
    bit         rd;
    close_open_txn();
    rd = $urandom_range(1);
    r  = $urandom_range(99);
    if (r < 70)      cnt = 7'($urandom_range(4, 1));
    else if (r < 80) cnt = 7'd0;
    else if (r < 93) cnt = 7'($urandom_range(16, 5));
    else             cnt = 7'($urandom_range(127, 64));
    n = (cnt == 0) ? 1 : (cnt > MAX_REGS_DEF) ? MAX_REGS_DEF : int'(cnt);
    send_start(rd ? CMD_START_READ : CMD_START_WRITE, rand_addr(), cnt);
    f.push_back(8'($urandom));
    r = $urandom_range(99);
    if (rd) begin
      f.push_back((r < 78) ? FUNC_READ_HOLD :
                  (r < 90) ? (FUNC_READ_HOLD | EXC_MASK) : 8'($urandom));
      f.push_back(($urandom_range(99) < 75) ? 8'(2 * n) : 8'($urandom));
      repeat (2 * n) f.push_back(8'($urandom));
    end else begin
      f.push_back((r < 78) ? FUNC_WRITE_SINGLE :
                  (r < 90) ? (FUNC_WRITE_SINGLE | EXC_MASK) : 8'($urandom));
      repeat (4) f.push_back(8'($urandom));
    end
    f = with_crc(f);
    if ($urandom_range(99) < 10) begin
      r    = $urandom_range(f.size() - 1);
      f[r] = f[r] ^ 8'(1 << $urandom_range(7));
    end
    if ($urandom_range(99) < 6) begin
      r = $urandom_range(f.size() - 1);
      while (f.size() > r) void'(f.pop_back());
    end
    send_frame(f, 6);
  endtask

  // Lowers valid and waits until every predicted result has come out, then
  // lets the block settle for transfers that cause no result.
  task automatic settle();
    item_valid <= 1'b0;
    while (txn_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_reg_t idx, logic [15:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    if (idx == REG_LINK_UP) link_open = v[0];
    else tmo_limit = v;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // Out of reset the link is down: bytes and ticks are ignored, and every
  // start is answered with a not-connected result.
  task automatic test_idle_and_link_down();
    send_tick();
    send_byte(8'hFF);
    send_start(CMD_START_READ, 16'hFFFF, 7'd1);
    send_start(CMD_START_WRITE, 16'h0000, 7'h7F);
    settle();
  endtask

  // One good write, one good read of a single register asked with count
  // zero, a start while busy, and a write that times out.
  task automatic test_basic_frames();
    write_cfg(REG_LINK_UP, 16'd1);
    write_cfg(REG_TIMEOUT_TICKS, 16'd3);
    send_start(CMD_START_WRITE, 16'h1234, 7'd0);
    send_start(CMD_START_READ, 16'h5678, 7'd2);
    send_frame(with_crc('{8'h11, FUNC_WRITE_SINGLE, 8'h12, 8'h34, 8'h00, 8'h00}), 0);
    send_start(CMD_START_READ, 16'hFFFF, 7'd0);
    send_frame(with_crc('{8'h11, FUNC_READ_HOLD, 8'h02, 8'hFF, 8'hFF}), 0);
    send_start(CMD_START_WRITE, 16'hABCD, 7'd1);
    repeat (3) send_tick();
    settle();
  endtask

  // An odd byte count drops its last byte; a count below two gives nothing.
  task automatic test_byte_count_field();
    send_start(CMD_START_READ, 16'h0100, 7'd2);
    send_frame(with_crc('{8'h01, FUNC_READ_HOLD, 8'h05, 8'h12, 8'h34, 8'hAB, 8'hCD}), 0);
    send_start(CMD_START_READ, 16'h0200, 7'd1);
    send_frame(with_crc('{8'h01, FUNC_READ_HOLD, 8'h01, 8'h00, 8'h80}), 0);
    settle();
  endtask

  // With the largest timeout a few ticks pass and the response still
  // completes; a timeout of zero acts as one and expires on the first tick.
  task automatic test_timeout_extremes();
    write_cfg(REG_TIMEOUT_TICKS, 16'(TICKS_MAX));
    send_start(CMD_START_WRITE, rand_addr(), 7'($urandom));
    repeat (5) send_tick();
    send_frame(with_crc('{8'h11, FUNC_WRITE_SINGLE, 8'h00, 8'h10, 8'hBE, 8'hEF}), 0);
    settle();
    write_cfg(REG_TIMEOUT_TICKS, 16'h0000);
    send_start(CMD_START_READ, rand_addr(), 7'($urandom));
    send_tick();
    settle();
  endtask

  // The receiver holds off while a 16-register read replays and the sender
  // keeps offering the next transaction, so the block has to stall its
  // input. Then the sender waits until every result is out.
  task automatic test_backpressure();
    frame_t f;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    @(negedge clk) hold_left = HOLD_OFF_CYCLES;
    @(posedge clk);
    // A byte count of 255 clamps to the 16 registers asked.
    send_start(CMD_START_READ, 16'hFFFF, 7'd16);
    f = '{8'h01, FUNC_READ_HOLD, 8'hFF};
    repeat (2 * 16) f.push_back(8'($urandom));
    send_frame(with_crc(f), 0);
    send_start(CMD_START_WRITE, 16'h0000, 7'h40);
    send_frame(with_crc('{8'hF7, FUNC_WRITE_SINGLE, 8'h00, 8'h00, 8'hFF, 8'hFF}), 0);
    settle();
    send_start(CMD_START_READ, 16'h8000, 7'd4);
    f = '{8'h01, FUNC_READ_HOLD, 8'h08};
    repeat (8) f.push_back(8'($urandom));
    send_frame(with_crc(f), 0);
    settle();
  endtask

  // Random transactions with a little noise, at the given idle and stall
  // rates and timeout. With link_drop the link goes down for a few transfers
  // first, possibly while a transaction is still open.
  task automatic test_random_mix(int tx_pct, int rx_pct, logic [15:0] tmo,
                                 int n_items, bit link_drop);
    int first;
    settle();
    write_cfg(REG_TIMEOUT_TICKS, tmo);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    if (link_drop) begin
      write_cfg(REG_LINK_UP, 16'd0);
      send_start(CMD_START_READ, rand_addr(), 7'($urandom));
      repeat (5) send_noise();
      settle();
      write_cfg(REG_LINK_UP, 16'd1);
    end
    first = effective_items;
    while (effective_items - first < n_items) begin
      if ($urandom_range(99) < 12) send_noise();
      else send_txn();
    end
    settle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_idle_and_link_down();
    test_basic_frames();
    test_byte_count_field();
    test_timeout_extremes();
    test_backpressure();
    test_random_mix(0, 0, 16'hFFFF, 15, 1'b0);
    test_random_mix(83, 0, 16'd4, 15, 1'b0);
    test_random_mix(0, 83, 16'd9, 15, 1'b0);
    test_random_mix(23, 23, 16'd2, 15, 1'b1);

    // Everything predicted has been checked; give stray results a chance.
    settle();
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
